[rtl/tmrc_pkg.sv]
// Shared constants and types of the tile map rectangle collision unit.
`default_nettype none

package tmrc_pkg;

  localparam int unsigned TILE_W       = 8;   // tile number
  localparam int unsigned RECT_W       = 16;  // signed rectangle edge
  localparam int unsigned DIV_W        = 15;  // non-negative dividend / quotient
  localparam int unsigned PIX_W        = 16;  // internal tile bound width
  localparam int unsigned OUT_W        = 12;  // output bound field
  localparam int unsigned S_TDATA_W    = 88;
  localparam int unsigned M_TDATA_W    = 48;
  localparam logic [TILE_W-1:0] PASSABLE_RST = 8'd60;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

[rtl/tmrc_div.sv]
// Divider of a non-negative value by a constant divisor, by reciprocal multiplication.
`default_nettype none

module tmrc_div #(
  parameter int unsigned DIVISOR = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [tmrc_pkg::DIV_W-1:0] dividend_i,
  output logic                            busy_o,
  output logic [tmrc_pkg::DIV_W-1:0]      quot_o
);
  import tmrc_pkg::*;

  // q = (x * ceil(2^SH / d)) >> SH is exact for x < 2^DIV_W when SH = DIV_W + clog2(d)
  localparam int unsigned     SH    = DIV_W + $clog2(DIVISOR);
  localparam int unsigned     PW    = 2 * DIV_W + 2;
  localparam longint unsigned RECIP = ((longint'(1) << SH) + DIVISOR - 1) / DIVISOR;

  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0] quot_q, quot_d;
  logic             busy_q, busy_d;
  logic [PW-1:0]    prod;

  // dividend registered on start, quotient registered from it in the following cycle
  always_comb begin
    prod   = PW'(dvd_q) * PW'(RECIP);
    dvd_d  = start_i ? dividend_i : dvd_q;
    busy_d = start_i;
    quot_d = DIV_W'(prod >> SH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[rtl/tile_map_rect_collision_unit.sv]
// Tile map rectangle collision unit: tile store, query window scan and output register.
//
// Holds a MAP_COLS x MAP_ROWS grid of 8-bit tile numbers in one synchronous
// RAM. A write beat (tuser = 0) stores a tile and returns nothing; writes
// outside the grid are dropped. A query beat (tuser = 1) returns one beat: the
// first non-passable tile, in row-major order, whose square touches or
// overlaps the rectangle. A query runs from its beat through the reciprocal-
// multiply dividers that turn the rectangle into a tile window, a scan with
// one RAM read per cycle over the window tiles up to the first hit, each
// checked on the registered read data, and the load of the output register,
// after which the next beat can be taken; an empty window skips the scan. The
// load waits while the output register holds a beat the sink has not taken.
// The next beat is taken while a result still waits in the output register.
// After reset the RAM is cleared, one entry per cycle, over all MAP_COLS *
// MAP_ROWS entries (2048 by default); no beat is taken during that pass,
// configuration writes are.
`default_nettype none

module tile_map_rect_collision_unit #(
  parameter int unsigned MAP_COLS  = 64,
  parameter int unsigned MAP_ROWS  = 32,
  parameter int unsigned TILE_SIZE = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tile_col[5:0], tile_row[10:6], tile_value[18:11], rect_left[34:19],
  // rect_top[50:35], rect_right[66:51], rect_bottom[82:67], zero pad
  input  wire logic [tmrc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  wire logic                          s_axis_tuser,   // mode
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // hit_left[11:0], hit_top[23:12], hit_right[35:24], hit_bottom[47:36]
  output logic [tmrc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tuser,   // hit
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic [tmrc_pkg::TILE_W-1:0]   cfg_data_i,     // passable_tile
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o
);
  import tmrc_pkg::*;

  localparam int unsigned DEPTH = MAP_COLS * MAP_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
  localparam int unsigned RIW   = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

  // ---------------- input fields ----------------
  logic [5:0]               in_col;
  logic [4:0]               in_row;
  logic [TILE_W-1:0]        in_value;
  logic signed [RECT_W-1:0] in_left, in_top, in_right, in_bottom;

  assign in_col    = s_axis_tdata[5:0];
  assign in_row    = s_axis_tdata[10:6];
  assign in_value  = s_axis_tdata[18:11];
  assign in_left   = s_axis_tdata[34:19];
  assign in_top    = s_axis_tdata[50:35];
  assign in_right  = s_axis_tdata[66:51];
  assign in_bottom = s_axis_tdata[82:67];

  // ---------------- state ----------------
  state_e            state_q, state_d;
  logic [TILE_W-1:0] passable_q;
  logic [AW-1:0]     clr_addr_q, clr_addr_d;

  logic              col_none_q, col_none_d, row_none_q, row_none_d;
  logic [CW-1:0]     c_lo_q, c_lo_d, c_hi_q, c_hi_d;
  logic [RIW-1:0]    r_hi_q, r_hi_d;
  logic [CW-1:0]     iss_c_q, iss_c_d;
  logic [RIW-1:0]    iss_r_q, iss_r_d;
  logic              iss_done_q, iss_done_d;
  logic              rd_valid_q, rd_valid_d, rd_last_q, rd_last_d;
  logic [CW-1:0]     rd_c_q, rd_c_d;
  logic [RIW-1:0]    rd_r_q, rd_r_d;

  logic              res_hit_q, res_hit_d;
  logic [CW-1:0]     res_c_q, res_c_d;
  logic [RIW-1:0]    res_r_q, res_r_d;

  logic [M_TDATA_W-1:0] out_data_q, out_data_d;
  logic                 out_hit_q, out_hit_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;

  // ---------------- tile RAM ----------------
  logic [TILE_W-1:0] tile_mem [DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [TILE_W-1:0] mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tile_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= tile_mem[mem_raddr];
  end

  // ---------------- window dividers ----------------
  logic                  in_accept, div_start, div_busy;
  logic [3:0]            lane_busy;
  logic [DIV_W-1:0]      lane_dvd  [4];
  logic [DIV_W-1:0]      lane_quot [4];

  assign in_accept = s_axis_tvalid & s_axis_tready;
  assign div_start = in_accept & (s_axis_tuser == MODE_QUERY);

  // lanes: first column, last column, first row, last row
  // first index = floor((edge - 1) / size) for edge > 0, else 0
  assign lane_dvd[0] = (in_left > 0) ? DIV_W'(in_left - RECT_W'(1)) : '0;
  assign lane_dvd[1] = in_right[DIV_W-1:0];
  assign lane_dvd[2] = (in_top > 0) ? DIV_W'(in_top - RECT_W'(1)) : '0;
  assign lane_dvd[3] = in_bottom[DIV_W-1:0];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    tmrc_div #(
      .DIVISOR (TILE_SIZE)
    ) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (lane_dvd[g]),
      .busy_o     (lane_busy[g]),
      .quot_o     (lane_quot[g])
    );
  end

  assign div_busy = |lane_busy;

  // ---------------- window limits ----------------
  logic [DIV_W-1:0] qc_hi_clamp, qr_hi_clamp;
  logic             win_empty;

  always_comb begin
    qc_hi_clamp = (lane_quot[1] > DIV_W'(MAP_COLS - 1)) ? DIV_W'(MAP_COLS - 1) : lane_quot[1];
    qr_hi_clamp = (lane_quot[3] > DIV_W'(MAP_ROWS - 1)) ? DIV_W'(MAP_ROWS - 1) : lane_quot[3];
    win_empty   = col_none_q | row_none_q |
                  (lane_quot[0] > qc_hi_clamp) | (lane_quot[2] > qr_hi_clamp);
  end

  // ---------------- output bounds ----------------
  logic [PIX_W-1:0] bnd_l, bnd_t, bnd_r, bnd_b;

  always_comb begin
    bnd_l = PIX_W'(res_c_q) * PIX_W'(TILE_SIZE);
    bnd_t = PIX_W'(res_r_q) * PIX_W'(TILE_SIZE);
    bnd_r = bnd_l + PIX_W'(TILE_SIZE);
    bnd_b = bnd_t + PIX_W'(TILE_SIZE);
  end

  // ---------------- control ----------------
  logic write_in_grid;
  logic iss_last;

  assign write_in_grid = (32'(in_col) < MAP_COLS) && (32'(in_row) < MAP_ROWS);
  assign iss_last      = (iss_c_q == c_hi_q) && (iss_r_q == r_hi_q);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    col_none_d  = col_none_q;
    row_none_d  = row_none_q;
    c_lo_d      = c_lo_q;
    c_hi_d      = c_hi_q;
    r_hi_d      = r_hi_q;
    iss_c_d     = iss_c_q;
    iss_r_d     = iss_r_q;
    iss_done_d  = iss_done_q;
    rd_valid_d  = 1'b0;
    rd_last_d   = rd_last_q;
    rd_c_d      = rd_c_q;
    rd_r_d      = rd_r_q;
    res_hit_d   = res_hit_q;
    res_c_d     = res_c_q;
    res_r_d     = res_r_q;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = AW'(in_row) * AW'(MAP_COLS) + AW'(in_col);
    mem_wdata   = in_value;
    mem_raddr   = AW'(iss_r_q) * AW'(MAP_COLS) + AW'(iss_c_q);

    unique case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser == MODE_QUERY) begin
            col_none_d = in_right[RECT_W-1];
            row_none_d = in_bottom[RECT_W-1];
            state_d    = ST_DIV;
          end else begin
            mem_we = write_in_grid;
          end
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          c_lo_d     = CW'(lane_quot[0]);
          c_hi_d     = CW'(qc_hi_clamp);
          r_hi_d     = RIW'(qr_hi_clamp);
          iss_c_d    = CW'(lane_quot[0]);
          iss_r_d    = RIW'(lane_quot[2]);
          iss_done_d = 1'b0;
          if (win_empty) begin
            res_hit_d = 1'b0;
            state_d   = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue one read per cycle; check the one issued in the cycle before
        if (!iss_done_q) begin
          rd_valid_d = 1'b1;
          rd_last_d  = iss_last;
          rd_c_d     = iss_c_q;
          rd_r_d     = iss_r_q;
          iss_done_d = iss_last;
          if (iss_c_q == c_hi_q) begin
            iss_c_d = c_lo_q;
            iss_r_d = iss_r_q + RIW'(1);
          end else begin
            iss_c_d = iss_c_q + CW'(1);
          end
        end
        if (rd_valid_q) begin
          if (mem_rdata_q != passable_q) begin
            res_hit_d  = 1'b1;
            res_c_d    = rd_c_q;
            res_r_d    = rd_r_q;
            rd_valid_d = 1'b0;
            state_d    = ST_DONE;
          end else if (rd_last_q) begin
            res_hit_d = 1'b0;
            state_d   = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_d  = out_data_q;
    out_hit_d   = out_hit_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_hit_d   = res_hit_q;
      out_data_d  = res_hit_q ? {bnd_b[OUT_W-1:0], bnd_r[OUT_W-1:0],
                                 bnd_t[OUT_W-1:0], bnd_l[OUT_W-1:0]} : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      passable_q  <= PASSABLE_RST;
      iss_done_q  <= 1'b1;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      iss_done_q  <= iss_done_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        passable_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    col_none_q <= col_none_d;
    row_none_q <= row_none_d;
    c_lo_q     <= c_lo_d;
    c_hi_q     <= c_hi_d;
    r_hi_q     <= r_hi_d;
    iss_c_q    <= iss_c_d;
    iss_r_q    <= iss_r_d;
    rd_last_q  <= rd_last_d;
    rd_c_q     <= rd_c_d;
    rd_r_q     <= rd_r_d;
    res_hit_q  <= res_hit_d;
    res_c_q    <= res_c_d;
    res_r_q    <= res_r_d;
    out_data_q <= out_data_d;
    out_hit_q  <= out_hit_d;
  end

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tvalid = out_valid_q;

  // ---------------- checks ----------------
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss beat with nonzero bounds");

  a_hit_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[35:24] == OUT_W'(m_axis_tdata[11:0] + OUT_W'(TILE_SIZE)))
    else $error("hit right bound not left plus tile size");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || m_axis_tready)
    else $error("pending result overwritten");

  a_read_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && rd_valid_q |-> rd_c_q >= c_lo_q && rd_c_q <= c_hi_q &&
      rd_r_q <= r_hi_q)
    else $error("scan read outside tile window");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !s_axis_tready && !m_axis_tvalid)
    else $error("traffic during RAM clear");

endmodule

`default_nettype wire

[tb/tile_map_rect_collision_unit_tb.sv]
// Testbench for the tile map rectangle collision unit: directed and random beats, scoreboard.
`timescale 1ns / 100ps

module tile_map_rect_collision_unit_tb;
  import tmrc_pkg::*;

  localparam int MAP_COLS  = 64;
  localparam int MAP_ROWS  = 32;
  localparam int TILE_SIZE = 32;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] left;
    logic [OUT_W-1:0] top;
    logic [OUT_W-1:0] right;
    logic [OUT_W-1:0] bottom;
  } collision_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TILE_W-1:0]    cfg_data_i    = '0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;

  // predictor state
  logic [TILE_W-1:0] tile_mem [MAP_COLS*MAP_ROWS] = '{default: '0};
  logic [TILE_W-1:0] passable_q = PASSABLE_RST;
  collision_t        pending_hits [$];

  int mismatch_count = 0;
  int src_idle_pct   = 27;
  int sink_idle_pct  = 76;
  int hold_requests  = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  tile_map_rect_collision_unit #(
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS),
    .TILE_SIZE(TILE_SIZE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_data_i   (cfg_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // long sink stall, counted down here
  always @(posedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= (hold_left == 0) && (int'($urandom_range(99)) >= sink_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // row-major scan for the first solid tile touching the rectangle
  function automatic collision_t find_first_hit(input logic signed [RECT_W-1:0] l,
                                                input logic signed [RECT_W-1:0] t,
                                                input logic signed [RECT_W-1:0] r,
                                                input logic signed [RECT_W-1:0] b);
    collision_t res;
    int li, ti, ri, bi;
    int tl, tt, tr, tbt;
    res = '0;
    li = l;
    ti = t;
    ri = r;
    bi = b;
    for (int row = 0; row < MAP_ROWS; row++) begin
      for (int col = 0; col < MAP_COLS; col++) begin
        if (tile_mem[row*MAP_COLS + col] == passable_q) continue;
        tl  = col * TILE_SIZE;
        tt  = row * TILE_SIZE;
        tr  = tl + TILE_SIZE;
        tbt = tt + TILE_SIZE;
        if (tl > ri || tt > bi || tr < li || tbt < ti) continue;
        res.hit    = 1'b1;
        res.left   = tl[OUT_W-1:0];
        res.top    = tt[OUT_W-1:0];
        res.right  = tr[OUT_W-1:0];
        res.bottom = tbt[OUT_W-1:0];
        return res;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    collision_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("result beat with no query outstanding");
      end else begin
        want = pending_hits.pop_front();
        if (m_axis_tuser !== want.hit)
          report_mismatch($sformatf("hit %b, want %b", m_axis_tuser, want.hit));
        if (m_axis_tdata[11:0] !== want.left)
          report_mismatch($sformatf("hit_left %0d, want %0d", m_axis_tdata[11:0], want.left));
        if (m_axis_tdata[23:12] !== want.top)
          report_mismatch($sformatf("hit_top %0d, want %0d", m_axis_tdata[23:12], want.top));
        if (m_axis_tdata[35:24] !== want.right)
          report_mismatch($sformatf("hit_right %0d, want %0d", m_axis_tdata[35:24], want.right));
        if (m_axis_tdata[47:36] !== want.bottom)
          report_mismatch($sformatf("hit_bottom %0d, want %0d", m_axis_tdata[47:36],
                                    want.bottom));
      end
    end
  end

  // Called right after the clock rises. Valid stays high into the next beat unless
  // the source idles, in which case it is lowered and the source waits before raising it again.
  task automatic send_beat(input logic mode, input logic [5:0] col, input logic [4:0] row,
                           input logic [TILE_W-1:0] val,
                           input logic signed [RECT_W-1:0] l, input logic signed [RECT_W-1:0] t,
                           input logic signed [RECT_W-1:0] r, input logic signed [RECT_W-1:0] b);
    if (int'($urandom_range(99)) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (int'($urandom_range(99)) < src_idle_pct);
    end
    s_axis_tdata  <= {5'b0, b, r, t, l, val, row, col};
    s_axis_tuser  <= mode;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (mode == MODE_WRITE) begin
      if (int'(col) < MAP_COLS && int'(row) < MAP_ROWS)
        tile_mem[int'(row)*MAP_COLS + int'(col)] = val;
    end else begin
      pending_hits.push_back(find_first_hit(l, t, r, b));
    end
  endtask

  task automatic send_query(input int l, input int t, input int r, input int b);
    send_beat(MODE_QUERY, 6'($urandom), 5'($urandom), 8'($urandom),
              RECT_W'(l), RECT_W'(t), RECT_W'(r), RECT_W'(b));
  endtask

  task automatic send_write(input int col, input int row, input int val);
    send_beat(MODE_WRITE, 6'(col), 5'(row), 8'(val),
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // stop offering, let every result out, then give trailing writes time to land
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_passable(input logic [TILE_W-1:0] value);
    wait_idle();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    passable_q = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_beat();
    int kind, l, t, w, h, c, r;
    if ($urandom_range(99) < 45) begin
      kind = $urandom_range(9);
      if (kind < 4)      send_write($urandom_range(63), $urandom_range(31), passable_q);
      else if (kind < 6) send_write($urandom_range(63), $urandom_range(31), 0);
      else if (kind < 7) send_write($urandom_range(63), $urandom_range(31), 255);
      else               send_write($urandom_range(63), $urandom_range(31), $urandom_range(255));
    end else begin
      kind = $urandom_range(39);
      l = int'($urandom_range(2200)) - 100;
      t = int'($urandom_range(1200)) - 100;
      w = $urandom_range(80);
      h = $urandom_range(80);
      if (kind < 28) begin
        send_query(l, t, l + w, t + h);
      end else if (kind < 33) begin
        // inverted rectangle, edges kept as given
        send_query(l + w + 1, t + h + 1, l, t);
      end else if (kind < 38) begin
        // point on a tile corner
        c = $urandom_range(MAP_COLS) * TILE_SIZE;
        r = $urandom_range(MAP_ROWS) * TILE_SIZE;
        send_query(c, r, c, r);
      end else begin
        send_query($urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_reset_map();
    send_query(0, 0, 0, 0);
    send_query(-32768, -32768, -32768, -32768);
    send_query(32767, 32767, 32767, 32767);
    send_query(2048, 1024, 2048, 1024);
    send_query(-32768, -32768, 32767, 32767);
    send_query(32, 32, 40, 40);
    send_query(100, 100, 0, 0);
    send_query(20, 20, 10, 10);
    wait_idle();
  endtask

  task automatic test_tile_writes();
    send_beat(MODE_WRITE, 6'd63, 5'd31, 8'd255, '1, '1, '1, '1);
    send_beat(MODE_WRITE, 6'd0, 5'd0, 8'd60, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_write(1, 0, 0);
    send_query(0, 0, 0, 0);
    send_query(0, 0, 32, 32);
    send_query(2048, 1024, 2048, 1024);
    send_beat(MODE_QUERY, '1, '1, '1, 16'sd5, 16'sd5, 16'sd5, 16'sd5);
    wait_idle();
  endtask

  task automatic test_passable_register();
    write_passable(8'd255);
    send_query(2016, 992, 2048, 1024);
    send_query(2040, 1000, 2100, 1100);
    write_passable(8'd0);
    send_query(-32768, -32768, 32767, 32767);
    send_query(0, 0, 0, 0);
    write_passable(PASSABLE_RST);
    send_query(0, 0, 31, 31);
    wait_idle();
  endtask

  task automatic test_random(input int count, input int src_pct, input int sink_pct,
                             input logic [TILE_W-1:0] passable, input bit stall_sink);
    write_passable(passable);
    src_idle_pct = src_pct;
    sink_idle_pct <= sink_pct;
    if (stall_sink) hold_requests <= hold_requests + 1;
    repeat (count) send_random_beat();
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_map();
    test_tile_writes();
    test_passable_register();
    test_random(250, 27, 76, 8'd0, 1'b0);
    test_random(250, 76, 27, 8'($urandom_range(255)), 1'b0);
    test_random(250, 0, 0, PASSABLE_RST, 1'b1);
    if (mismatch_count == 0 && pending_hits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
